>>> sv/bbwa_pkg.sv
// ----------------------------------------------------------------------------
// bbwa_pkg
// Shared constants, types and helpers of the box blur window average block.
// ----------------------------------------------------------------------------
package bbwa_pkg;

  localparam int WINDOW      = 15;
  localparam int RAD_BEFORE  = WINDOW / 2;
  localparam int RAD_AFTER   = WINDOW - 1 - RAD_BEFORE;
  localparam int MAX_WIDTH   = 2048;
  localparam int STORE_DEPTH = (WINDOW - 1) * MAX_WIDTH + WINDOW;

  localparam int ADDR_W  = $clog2(STORE_DEPTH);
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int CFG_W   = 12;
  localparam int OY_W    = 12;
  localparam int ROW_W   = 13;
  localparam int TAKEN_W = 24;
  localparam int PIX_W   = 24;
  localparam int CH_W    = 8;
  localparam int CNT_W   = $clog2(WINDOW * WINDOW + 1);
  localparam int SUM_W   = $clog2(WINDOW * WINDOW * 255 + 1);
  localparam int DCNT_W  = $clog2(SUM_W + 1);

  localparam int NUM_REGS   = 2;
  localparam int PADDR_W    = 3;
  localparam int REG_WIDTH  = 0;
  localparam int REG_HEIGHT = 1;

  typedef struct packed {
    logic accept;
    logic acc_step;
    logic div_init;
    logic div_step;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic last;
    logic div_done;
    logic out_busy;
  } status_t;

  function automatic logic [ADDR_W-1:0] add_mod(input logic [ADDR_W-1:0] a,
                                                input logic [ADDR_W-1:0] b);
    logic [ADDR_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (ADDR_W+1)'(STORE_DEPTH)) begin
      s = s - (ADDR_W+1)'(STORE_DEPTH);
    end
    return s[ADDR_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] sub_mod(input logic [ADDR_W-1:0] a,
                                                input logic [ADDR_W-1:0] b);
    logic [ADDR_W:0] s;
    if (a >= b) begin
      s = {1'b0, a} - {1'b0, b};
    end else begin
      s = {1'b0, a} + (ADDR_W+1)'(STORE_DEPTH) - {1'b0, b};
    end
    return s[ADDR_W-1:0];
  endfunction

endpackage

>>> sv/bbwa_ram.sv
// ----------------------------------------------------------------------------
// bbwa_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module bbwa_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> sv/bbwa_ctrl.sv
// ----------------------------------------------------------------------------
// bbwa_ctrl
// Sequencer: takes one beat, walks the window through the store, divides,
// then hands the result to the output register.
// ----------------------------------------------------------------------------
module bbwa_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  bbwa_pkg::status_t status_i,
  output bbwa_pkg::cmd_t    cmd_o
);
  import bbwa_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_ACC   = 3'd2;
  localparam logic [2:0] S_DINIT = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && status_i.emit) begin
          state_d = S_RD;
        end
      end
      S_RD: begin
        state_d = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc_step = 1'b1;
        state_d        = status_i.last ? S_DINIT : S_RD;
      end
      S_DINIT: begin
        cmd_o.div_init = 1'b1;
        state_d        = S_DIV;
      end
      S_DIV: begin
        if (status_i.div_done) begin
          state_d = S_OUT;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_OUT: begin
        if (!status_i.out_busy) begin
          cmd_o.load = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> sv/bbwa_datapath.sv
// ----------------------------------------------------------------------------
// bbwa_datapath
// Raster counters, pixel store, window accumulator, divider and output
// register.
// ----------------------------------------------------------------------------
module bbwa_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [bbwa_pkg::CFG_W-1:0] w_eff_i,
  input  logic [bbwa_pkg::CFG_W-1:0] h_eff_i,
  input  logic                       restart_i,
  input  logic [7:0]                 in_red_i,
  input  logic [7:0]                 in_green_i,
  input  logic [7:0]                 in_blue_i,
  input  logic                       filler_i,
  input  bbwa_pkg::cmd_t             cmd_i,
  output bbwa_pkg::status_t          status_o,
  output logic [7:0]                 out_red_o,
  output logic [7:0]                 out_green_o,
  output logic [7:0]                 out_blue_o,
  output logic                       frame_end_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i
);
  import bbwa_pkg::*;

  // input side raster position
  logic [COL_W-1:0]   col_q;
  logic [ROW_W-1:0]   row_q;
  logic [TAKEN_W-1:0] taken_q;
  logic [ADDR_W-1:0]  wr_addr_q;
  // output side raster position
  logic [COL_W-1:0]   ox_q;
  logic [OY_W-1:0]    oy_q;
  logic [ADDR_W-1:0]  out_addr_q;
  // window walk
  logic [COL_W-1:0]   cx_q, x0_q, x1_q;
  logic [OY_W-1:0]    cy_q, y1_q;
  logic [ADDR_W-1:0]  addr_q, stride_q;
  logic [SUM_W-1:0]   sr_q, sg_q, sb_q;
  logic [CNT_W-1:0]   cnt_q;
  // divider
  logic [SUM_W-1:0]   nr_q, ng_q, nb_q;
  logic [CNT_W-1:0]   rr_q, rg_q, rb_q;
  logic [DCNT_W-1:0]  dcnt_q;
  // output register
  logic [CH_W-1:0]    or_q, og_q, ob_q;
  logic               oend_q, ovalid_q;

  logic [ADDR_W-1:0]  lag;
  logic               ignore;
  logic               in_frame;
  logic [TAKEN_W-1:0] taken_nx;
  logic               pass;
  logic [CFG_W-1:0]   x1_full;
  logic [OY_W:0]      y1_full;
  logic [COL_W-1:0]   x0_n, x1_n;
  logic [OY_W-1:0]    y0_n, y1_n;
  logic [PIX_W-1:0]   rd_data;
  logic               frame_last;

  assign lag      = ADDR_W'(RAD_AFTER * int'(w_eff_i) + RAD_AFTER);
  assign in_frame = {1'b0, row_q} < {2'b0, h_eff_i};
  assign ignore   = in_frame && filler_i;
  assign taken_nx = taken_q + TAKEN_W'(1);

  assign pass    = (ox_q < COL_W'(RAD_BEFORE)) || (oy_q < OY_W'(RAD_BEFORE));
  assign x1_full = CFG_W'(ox_q) + CFG_W'(RAD_AFTER);
  assign y1_full = (OY_W+1)'(oy_q) + (OY_W+1)'(RAD_AFTER);

  always_comb begin
    if (pass) begin
      x0_n = ox_q;
      x1_n = ox_q;
      y0_n = oy_q;
      y1_n = oy_q;
    end else begin
      x0_n = ox_q - COL_W'(RAD_BEFORE);
      y0_n = oy_q - OY_W'(RAD_BEFORE);
      x1_n = (x1_full > w_eff_i - CFG_W'(1)) ? COL_W'(w_eff_i - CFG_W'(1))
                                              : x1_full[COL_W-1:0];
      y1_n = (y1_full > {1'b0, h_eff_i} - (OY_W+1)'(1)) ? (h_eff_i - CFG_W'(1))
                                                        : y1_full[OY_W-1:0];
    end
  end

  assign frame_last = ({1'b0, ox_q} == w_eff_i - CFG_W'(1)) &&
                      (oy_q == h_eff_i - CFG_W'(1));

  assign status_o.emit     = !ignore && ({{(TAKEN_W-ADDR_W){1'b0}}, lag} < taken_nx);
  assign status_o.last     = (cx_q == x1_q) && (cy_q == y1_q);
  assign status_o.div_done = dcnt_q == DCNT_W'(SUM_W);
  assign status_o.out_busy = ovalid_q && out_stall_i;

  bbwa_ram #(
    .WIDTH (PIX_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (cmd_i.accept && in_frame && !filler_i),
    .wr_addr_i (wr_addr_q),
    .wr_data_i ({in_blue_i, in_green_i, in_red_i}),
    .rd_addr_i (addr_q),
    .rd_data_o (rd_data)
  );

  // raster counters on both sides
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      taken_q    <= '0;
      wr_addr_q  <= '0;
      ox_q       <= '0;
      oy_q       <= '0;
      out_addr_q <= '0;
    end else if (restart_i || (cmd_i.load && frame_last)) begin
      col_q      <= '0;
      row_q      <= '0;
      taken_q    <= '0;
      wr_addr_q  <= '0;
      ox_q       <= '0;
      oy_q       <= '0;
      out_addr_q <= '0;
    end else begin
      if (cmd_i.accept && !ignore) begin
        taken_q   <= taken_nx;
        wr_addr_q <= add_mod(wr_addr_q, ADDR_W'(1));
        if ({1'b0, col_q} == w_eff_i - CFG_W'(1)) begin
          col_q <= '0;
          row_q <= row_q + ROW_W'(1);
        end else begin
          col_q <= col_q + COL_W'(1);
        end
      end
      if (cmd_i.load) begin
        out_addr_q <= add_mod(out_addr_q, ADDR_W'(1));
        if ({1'b0, ox_q} == w_eff_i - CFG_W'(1)) begin
          ox_q <= '0;
          oy_q <= oy_q + OY_W'(1);
        end else begin
          ox_q <= ox_q + COL_W'(1);
        end
      end
    end
  end

  // window walk and accumulation
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      x0_q     <= x0_n;
      x1_q     <= x1_n;
      y1_q     <= y1_n;
      cx_q     <= x0_n;
      cy_q     <= y0_n;
      stride_q <= ADDR_W'(w_eff_i) - ADDR_W'(x1_n - x0_n);
      addr_q   <= pass ? out_addr_q : sub_mod(out_addr_q, lag);
      sr_q     <= '0;
      sg_q     <= '0;
      sb_q     <= '0;
      cnt_q    <= '0;
    end else if (cmd_i.acc_step) begin
      sr_q  <= sr_q + SUM_W'(rd_data[7:0]);
      sg_q  <= sg_q + SUM_W'(rd_data[15:8]);
      sb_q  <= sb_q + SUM_W'(rd_data[23:16]);
      cnt_q <= cnt_q + CNT_W'(1);
      if (cx_q == x1_q) begin
        cx_q   <= x0_q;
        cy_q   <= cy_q + OY_W'(1);
        addr_q <= add_mod(addr_q, stride_q);
      end else begin
        cx_q   <= cx_q + COL_W'(1);
        addr_q <= add_mod(addr_q, ADDR_W'(1));
      end
    end
  end

  // restoring divider, one quotient bit per cycle on all three channels
  function automatic logic [CNT_W+SUM_W-1:0] div_bit(input logic [CNT_W-1:0] r,
                                                     input logic [SUM_W-1:0] n,
                                                     input logic [CNT_W-1:0] d);
    logic [CNT_W:0] t;
    logic           qb;
    t  = {r, n[SUM_W-1]};
    qb = t >= {1'b0, d};
    if (qb) begin
      t = t - {1'b0, d};
    end
    return {t[CNT_W-1:0], n[SUM_W-2:0], qb};
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
    end else if (cmd_i.div_init) begin
      dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      dcnt_q <= dcnt_q + DCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      nr_q <= sr_q;
      ng_q <= sg_q;
      nb_q <= sb_q;
      rr_q <= '0;
      rg_q <= '0;
      rb_q <= '0;
    end else if (cmd_i.div_step) begin
      {rr_q, nr_q} <= div_bit(rr_q, nr_q, cnt_q);
      {rg_q, ng_q} <= div_bit(rg_q, ng_q, cnt_q);
      {rb_q, nb_q} <= div_bit(rb_q, nb_q, cnt_q);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd_i.load) begin
      ovalid_q <= 1'b1;
    end else if (!out_stall_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      or_q   <= nr_q[CH_W-1:0];
      og_q   <= ng_q[CH_W-1:0];
      ob_q   <= nb_q[CH_W-1:0];
      oend_q <= frame_last;
    end
  end

  assign out_red_o   = or_q;
  assign out_green_o = og_q;
  assign out_blue_o  = ob_q;
  assign frame_end_o = oend_q;
  assign out_valid_o = ovalid_q;

endmodule

>>> sv/box_blur_window_average.sv
// ----------------------------------------------------------------------------
// box_blur_window_average
// 15x15 box blur over an RGB raster stream with configurable frame size.
// ----------------------------------------------------------------------------
// sequence: a beat that completes a window is taken, then the n in-image pixels of the window
//   (1 for pass-through pixels) are read and summed, the sums are divided and the result is loaded
// flow: one beat at a time; a beat with no result is taken at once, other beats stall the input
//   while the single read port of the pixel store, the divider and a stalled output are busy
// reset: frame size 640x480, frame position zero, pixel store not cleared
module box_blur_window_average (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bbwa_pkg::PADDR_W-1:0]    paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [7:0]                      in_red_i,
  input  logic [7:0]                      in_green_i,
  input  logic [7:0]                      in_blue_i,
  input  logic                            filler_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [7:0]                      out_red_o,
  output logic [7:0]                      out_green_o,
  output logic [7:0]                      out_blue_o,
  output logic                            frame_end_o
);
  import bbwa_pkg::*;

  logic [CFG_W-1:0] width_q, height_q;
  logic [CFG_W-1:0] w_eff, h_eff;
  logic             cfg_wr;
  logic             reg_idx;
  cmd_t             cmd;
  status_t          status;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_W'(640);
      height_q <= CFG_W'(480);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        1'(REG_WIDTH):  width_q  <= pwdata[CFG_W-1:0];
        1'(REG_HEIGHT): height_q <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      1'(REG_WIDTH):  prdata = {{(32-CFG_W){1'b0}}, width_q};
      1'(REG_HEIGHT): prdata = {{(32-CFG_W){1'b0}}, height_q};
      default:        prdata = '0;
    endcase
  end

  // zero counts as one, oversize width clamps to the line store size
  always_comb begin
    if (width_q == '0) begin
      w_eff = CFG_W'(1);
    end else if (width_q > CFG_W'(MAX_WIDTH)) begin
      w_eff = CFG_W'(MAX_WIDTH);
    end else begin
      w_eff = width_q;
    end
    h_eff = (height_q == '0) ? CFG_W'(1) : height_q;
  end

  bbwa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bbwa_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .w_eff_i     (w_eff),
    .h_eff_i     (h_eff),
    .restart_i   (cfg_wr),
    .in_red_i    (in_red_i),
    .in_green_i  (in_green_i),
    .in_blue_i   (in_blue_i),
    .filler_i    (filler_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_red_o   (out_red_o),
    .out_green_o (out_green_o),
    .out_blue_o  (out_blue_o),
    .frame_end_o (frame_end_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i)
  );

endmodule
